FILE: sv/pslj_pkg.sv
package pslj_pkg;

  // signed Q16.16 word
  typedef logic signed [31:0] q_t;

  // value with its clip mark
  typedef struct packed {
    logic clip;
    q_t   v;
  } sat_t;

  // operands carried alongside the sine/cosine pipeline
  typedef struct packed {
    q_t ry;
    q_t fn;
    q_t ft;
  } ops_t;

  // configuration register file
  typedef struct packed {
    q_t xx;
    q_t xy;
    q_t xm;
    q_t yy;
    q_t ym;
    q_t mm;
    q_t lx;
    q_t po;
  } cfg_t;

  // one result, first entry first
  typedef struct packed {
    q_t da_x_theta;
    q_t da_y_theta;
    q_t da_x_ry;
    q_t da_y_ry;
    q_t da_theta_ry;
    q_t db_x_fn;
    q_t db_y_fn;
    q_t db_theta_fn;
    q_t db_x_ft;
    q_t db_y_ft;
    q_t db_theta_ft;
  } jac_t;

  typedef enum logic [2:0] {
    REG_LS_XX  = 3'd0,
    REG_LS_XY  = 3'd1,
    REG_LS_XM  = 3'd2,
    REG_LS_YY  = 3'd3,
    REG_LS_YM  = 3'd4,
    REG_LS_MM  = 3'd5,
    REG_LEVER_X = 3'd6,
    REG_PUSH_OFS = 3'd7
  } cfg_idx_e;

  localparam int CfgAddrW = 3;

  // angle constants in Q2.30
  localparam logic signed [34:0] Q30Pi     = 35'sd3373259426;
  localparam logic signed [34:0] Q30HalfPi = 35'sd1686629713;
  localparam logic signed [33:0] CordicX0  = 34'sd652032874;

  localparam logic signed [65:0] SatMax = 66'sd2147483647;
  localparam logic signed [65:0] SatMin = -66'sd2147483648;

  // arctangent of 2^-i in Q2.30
  function automatic logic [29:0] atan_q30(input int unsigned i);
    logic [29:0] r;
    case (i)
      0:  r = 30'd843314856;
      1:  r = 30'd497837829;
      2:  r = 30'd263043836;
      3:  r = 30'd133525158;
      4:  r = 30'd67021686;
      5:  r = 30'd33543515;
      6:  r = 30'd16775850;
      7:  r = 30'd8388437;
      8:  r = 30'd4194282;
      9:  r = 30'd2097149;
      10: r = 30'd1048575;
      11: r = 30'd524287;
      12: r = 30'd262143;
      13: r = 30'd131071;
      14: r = 30'd65535;
      15: r = 30'd32767;
      16: r = 30'd16383;
      17: r = 30'd8191;
      18: r = 30'd4095;
      19: r = 30'd2047;
      20: r = 30'd1023;
      21: r = 30'd511;
      22: r = 30'd255;
      23: r = 30'd127;
      24: r = 30'd63;
      25: r = 30'd31;
      26: r = 30'd15;
      27: r = 30'd8;
      28: r = 30'd4;
      29: r = 30'd2;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    if (v > SatMax) begin
      r.clip = 1'b1;
      r.v    = 32'sh7FFFFFFF;
    end else if (v < SatMin) begin
      r.clip = 1'b1;
      r.v    = 32'sh80000000;
    end else begin
      r.clip = 1'b0;
      r.v    = v[31:0];
    end
    return r;
  endfunction

  function automatic sat_t q_add(input q_t a, input q_t b);
    return sat32(66'(a) + 66'(b));
  endfunction

  function automatic sat_t q_sub(input q_t a, input q_t b);
    return sat32(66'(a) - 66'(b));
  endfunction

  function automatic sat_t q_neg(input q_t a);
    return sat32(-66'(a));
  endfunction

  // product rounded half up to Q16.16
  function automatic sat_t q_mul(input q_t a, input q_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat32((66'(p) + 66'sd32768) >>> 16);
  endfunction

endpackage

FILE: sv/pslj_cordic.sv
module pslj_cordic #(
  parameter int CORDIC_STEPS = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [18:0]      angle_i,
  input  pslj_pkg::ops_t   ops_i,
  output logic             valid_o,
  output pslj_pkg::q_t     sin_o,
  output pslj_pkg::q_t     cos_o,
  output pslj_pkg::ops_t   ops_o
);
  import pslj_pkg::*;

  localparam int N  = CORDIC_STEPS;
  localparam int XW = 34;
  localparam int ZW = 35;

  logic                 vld_q  [0:N+1];
  logic signed [XW-1:0] x_q    [0:N];
  logic signed [XW-1:0] y_q    [0:N];
  logic signed [ZW-1:0] z_q    [0:N];
  logic                 flip_q [0:N];
  ops_t                 ops_q  [0:N+1];
  q_t                   sin_q, cos_q;

  // range reduction into minus to plus half pi
  logic signed [ZW-1:0] z_in, z_d;
  logic                 flip_d;
  always_comb begin
    z_in   = ZW'($signed({angle_i, 14'b0}));
    z_d    = z_in;
    flip_d = 1'b0;
    if (z_in > Q30HalfPi) begin
      z_d    = z_in - Q30Pi;
      flip_d = 1'b1;
    end else if (z_in < -Q30HalfPi) begin
      z_d    = z_in + Q30Pi;
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CordicX0;
      y_q[0]    <= '0;
      z_q[0]    <= z_d;
      flip_q[0] <= flip_d;
      ops_q[0]  <= ops_i;
    end
  end

  // valid bits along the rotation stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= N + 1; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k <= N + 1; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // one rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [XW-1:0] xs, ys, x_d, y_d;
    logic signed [ZW-1:0] zn_d;
    always_comb begin
      xs = x_q[i] >>> i;
      ys = y_q[i] >>> i;
      if (!z_q[i][ZW-1]) begin
        x_d  = x_q[i] - ys;
        y_d  = y_q[i] + xs;
        zn_d = z_q[i] - ZW'(atan_q30(i));
      end else begin
        x_d  = x_q[i] + ys;
        y_d  = y_q[i] - xs;
        zn_d = z_q[i] + ZW'(atan_q30(i));
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= x_d;
        y_q[i+1]    <= y_d;
        z_q[i+1]    <= zn_d;
        flip_q[i+1] <= flip_q[i];
        ops_q[i+1]  <= ops_q[i];
      end
    end
  end

  // round to Q16.16 and undo the half turn
  logic signed [XW-1:0] xr, yr;
  q_t cos_d, sin_d;
  always_comb begin
    xr    = (x_q[N] + XW'(8192)) >>> 14;
    yr    = (y_q[N] + XW'(8192)) >>> 14;
    cos_d = 32'(xr);
    sin_d = 32'(yr);
    if (flip_q[N]) begin
      cos_d = -cos_d;
      sin_d = -sin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q      <= cos_d;
      sin_q      <= sin_d;
      ops_q[N+1] <= ops_q[N];
    end
  end

  assign valid_o = vld_q[N+1];
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;
  assign ops_o   = ops_q[N+1];

endmodule

FILE: sv/pslj_math.sv
module pslj_math (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  pslj_pkg::q_t    sin_i,
  input  pslj_pkg::q_t    cos_i,
  input  pslj_pkg::ops_t  ops_i,
  input  pslj_pkg::cfg_t  cfg_i,
  output logic            valid_o,
  output pslj_pkg::jac_t  jac_o,
  output logic            sat_o
);
  import pslj_pkg::*;

  logic [6:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  // stage 1: first products and contact offset
  q_t   s1_t2_q, s1_lf_q, s1_xxfn_q, s1_xyft_q, s1_xyfn_q, s1_yyft_q, s1_mmfn_q;
  q_t   s1_ymlx_q, s1_xmlx_q, s1_mmlx_q, s1_xmc_q, s1_yms_q, s1_xms_q, s1_ymc_q;
  q_t   s1_fn_q, s1_s_q, s1_c_q;
  logic s1_clip_q;
  sat_t a_t2, a_lf, a_xxfn, a_xyft, a_xyfn, a_yyft, a_mmfn, a_ymlx, a_xmlx, a_mmlx;
  sat_t a_xmc, a_yms, a_xms, a_ymc;
  always_comb begin
    a_t2   = q_add(cfg_i.po, ops_i.ry);
    a_lf   = q_mul(cfg_i.lx, ops_i.ft);
    a_xxfn = q_mul(cfg_i.xx, ops_i.fn);
    a_xyft = q_mul(cfg_i.xy, ops_i.ft);
    a_xyfn = q_mul(cfg_i.xy, ops_i.fn);
    a_yyft = q_mul(cfg_i.yy, ops_i.ft);
    a_mmfn = q_mul(cfg_i.mm, ops_i.fn);
    a_ymlx = q_mul(cfg_i.ym, cfg_i.lx);
    a_xmlx = q_mul(cfg_i.xm, cfg_i.lx);
    a_mmlx = q_mul(cfg_i.mm, cfg_i.lx);
    a_xmc  = q_mul(cfg_i.xm, cos_i);
    a_yms  = q_mul(cfg_i.ym, sin_i);
    a_xms  = q_mul(cfg_i.xm, sin_i);
    a_ymc  = q_mul(cfg_i.ym, cos_i);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_t2_q   <= a_t2.v;
      s1_lf_q   <= a_lf.v;
      s1_xxfn_q <= a_xxfn.v;
      s1_xyft_q <= a_xyft.v;
      s1_xyfn_q <= a_xyfn.v;
      s1_yyft_q <= a_yyft.v;
      s1_mmfn_q <= a_mmfn.v;
      s1_ymlx_q <= a_ymlx.v;
      s1_xmlx_q <= a_xmlx.v;
      s1_mmlx_q <= a_mmlx.v;
      s1_xmc_q  <= a_xmc.v;
      s1_yms_q  <= a_yms.v;
      s1_xms_q  <= a_xms.v;
      s1_ymc_q  <= a_ymc.v;
      s1_fn_q   <= ops_i.fn;
      s1_s_q    <= sin_i;
      s1_c_q    <= cos_i;
      s1_clip_q <= a_t2.clip | a_lf.clip | a_xxfn.clip | a_xyft.clip | a_xyfn.clip |
                   a_yyft.clip | a_mmfn.clip | a_ymlx.clip | a_xmlx.clip | a_mmlx.clip |
                   a_xmc.clip | a_yms.clip | a_xms.clip | a_ymc.clip;
    end
  end

  // stage 2: products with the offset and the force
  q_t   s2_t2fn_q, s2_ymt2_q, s2_xmt2_q, s2_mmt2_q, s2_pa_q, s2_qa_q, s2_r4_q;
  q_t   s2_b8_q, s2_b10_q, s2_r10_q, s2_xmcfn_q, s2_ymsfn_q, s2_xmsfn_q, s2_ymcfn_q;
  q_t   s2_lf_q, s2_s_q, s2_c_q;
  logic s2_clip_q;
  sat_t b_t2fn, b_ymt2, b_xmt2, b_mmt2, b_pa, b_qa, b_r4, b_b8, b_b10, b_r10;
  sat_t b_xmcfn, b_ymsfn, b_xmsfn, b_ymcfn;
  always_comb begin
    b_t2fn  = q_mul(s1_t2_q, s1_fn_q);
    b_ymt2  = q_mul(cfg_i.ym, s1_t2_q);
    b_xmt2  = q_mul(cfg_i.xm, s1_t2_q);
    b_mmt2  = q_mul(cfg_i.mm, s1_t2_q);
    b_pa    = q_add(s1_xxfn_q, s1_xyft_q);
    b_qa    = q_add(s1_xyfn_q, s1_yyft_q);
    b_r4    = q_neg(s1_mmfn_q);
    b_b8    = q_add(cfg_i.yy, s1_ymlx_q);
    b_b10   = q_add(cfg_i.xy, s1_xmlx_q);
    b_r10   = q_add(cfg_i.ym, s1_mmlx_q);
    b_xmcfn = q_mul(s1_xmc_q, s1_fn_q);
    b_ymsfn = q_mul(s1_yms_q, s1_fn_q);
    b_xmsfn = q_mul(s1_xms_q, s1_fn_q);
    b_ymcfn = q_mul(s1_ymc_q, s1_fn_q);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_t2fn_q  <= b_t2fn.v;
      s2_ymt2_q  <= b_ymt2.v;
      s2_xmt2_q  <= b_xmt2.v;
      s2_mmt2_q  <= b_mmt2.v;
      s2_pa_q    <= b_pa.v;
      s2_qa_q    <= b_qa.v;
      s2_r4_q    <= b_r4.v;
      s2_b8_q    <= b_b8.v;
      s2_b10_q   <= b_b10.v;
      s2_r10_q   <= b_r10.v;
      s2_xmcfn_q <= b_xmcfn.v;
      s2_ymsfn_q <= b_ymsfn.v;
      s2_xmsfn_q <= b_xmsfn.v;
      s2_ymcfn_q <= b_ymcfn.v;
      s2_lf_q    <= s1_lf_q;
      s2_s_q     <= s1_s_q;
      s2_c_q     <= s1_c_q;
      s2_clip_q  <= s1_clip_q | b_t2fn.clip | b_ymt2.clip | b_xmt2.clip | b_mmt2.clip |
                    b_pa.clip | b_qa.clip | b_r4.clip | b_b8.clip | b_b10.clip |
                    b_r10.clip | b_xmcfn.clip | b_ymsfn.clip | b_xmsfn.clip |
                    b_ymcfn.clip;
    end
  end

  // stage 3: torque term, input jacobian sums, rotated lever terms
  q_t   s3_t4_q, s3_b5_q, s3_b6_q, s3_r7_q, s3_r2_q, s3_r3_q;
  q_t   s3_cb10_q, s3_sb8_q, s3_cb8_q, s3_sb10_q;
  q_t   s3_pa_q, s3_qa_q, s3_r4_q, s3_r10_q, s3_s_q, s3_c_q;
  logic s3_clip_q;
  sat_t c_t4, c_b5, c_b6, c_r7, c_n2, c_r2, c_n3, c_r3, c_cb10, c_sb8, c_cb8, c_sb10;
  always_comb begin
    c_t4   = q_sub(s2_lf_q, s2_t2fn_q);
    c_b5   = q_sub(cfg_i.xy, s2_ymt2_q);
    c_b6   = q_sub(cfg_i.xx, s2_xmt2_q);
    c_r7   = q_sub(cfg_i.xm, s2_mmt2_q);
    c_n2   = q_neg(s2_xmcfn_q);
    c_r2   = q_add(c_n2.v, s2_ymsfn_q);
    c_n3   = q_neg(s2_xmsfn_q);
    c_r3   = q_sub(c_n3.v, s2_ymcfn_q);
    c_cb10 = q_mul(s2_c_q, s2_b10_q);
    c_sb8  = q_mul(s2_s_q, s2_b8_q);
    c_cb8  = q_mul(s2_c_q, s2_b8_q);
    c_sb10 = q_mul(s2_s_q, s2_b10_q);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_t4_q   <= c_t4.v;
      s3_b5_q   <= c_b5.v;
      s3_b6_q   <= c_b6.v;
      s3_r7_q   <= c_r7.v;
      s3_r2_q   <= c_r2.v;
      s3_r3_q   <= c_r3.v;
      s3_cb10_q <= c_cb10.v;
      s3_sb8_q  <= c_sb8.v;
      s3_cb8_q  <= c_cb8.v;
      s3_sb10_q <= c_sb10.v;
      s3_pa_q   <= s2_pa_q;
      s3_qa_q   <= s2_qa_q;
      s3_r4_q   <= s2_r4_q;
      s3_r10_q  <= s2_r10_q;
      s3_s_q    <= s2_s_q;
      s3_c_q    <= s2_c_q;
      s3_clip_q <= s2_clip_q | c_t4.clip | c_b5.clip | c_b6.clip | c_r7.clip |
                   c_n2.clip | c_r2.clip | c_n3.clip | c_r3.clip | c_cb10.clip |
                   c_sb8.clip | c_cb8.clip | c_sb10.clip;
    end
  end

  // stage 4: torque coupling, rotated normal-force products and the tangent-force columns
  q_t   s4_xmt4_q, s4_ymt4_q, s4_cb6_q, s4_sb5_q, s4_cb5_q, s4_sb6_q, s4_r8_q, s4_r9_q;
  q_t   s4_pa_q, s4_qa_q, s4_r2_q, s4_r3_q, s4_r4_q, s4_r7_q, s4_r10_q, s4_s_q, s4_c_q;
  logic s4_clip_q;
  sat_t d_xmt4, d_ymt4, d_cb6, d_sb5, d_cb5, d_sb6, d_r8, d_r9;
  always_comb begin
    d_xmt4 = q_mul(cfg_i.xm, s3_t4_q);
    d_ymt4 = q_mul(cfg_i.ym, s3_t4_q);
    d_cb6  = q_mul(s3_c_q, s3_b6_q);
    d_sb5  = q_mul(s3_s_q, s3_b5_q);
    d_cb5  = q_mul(s3_c_q, s3_b5_q);
    d_sb6  = q_mul(s3_s_q, s3_b6_q);
    d_r8   = q_sub(s3_cb10_q, s3_sb8_q);
    d_r9   = q_add(s3_cb8_q, s3_sb10_q);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_xmt4_q <= d_xmt4.v;
      s4_ymt4_q <= d_ymt4.v;
      s4_cb6_q  <= d_cb6.v;
      s4_sb5_q  <= d_sb5.v;
      s4_cb5_q  <= d_cb5.v;
      s4_sb6_q  <= d_sb6.v;
      s4_r8_q   <= d_r8.v;
      s4_r9_q   <= d_r9.v;
      s4_pa_q   <= s3_pa_q;
      s4_qa_q   <= s3_qa_q;
      s4_r2_q   <= s3_r2_q;
      s4_r3_q   <= s3_r3_q;
      s4_r4_q   <= s3_r4_q;
      s4_r7_q   <= s3_r7_q;
      s4_r10_q  <= s3_r10_q;
      s4_s_q    <= s3_s_q;
      s4_c_q    <= s3_c_q;
      s4_clip_q <= s3_clip_q | d_xmt4.clip | d_ymt4.clip | d_cb6.clip | d_sb5.clip |
                   d_cb5.clip | d_sb6.clip | d_r8.clip | d_r9.clip;
    end
  end

  // stage 5: body-frame velocity terms p and q, and the normal-force columns
  q_t   s5_p_q, s5_q_q, s5_r5_q, s5_r6_q;
  q_t   s5_r2_q, s5_r3_q, s5_r4_q, s5_r7_q, s5_r8_q, s5_r9_q, s5_r10_q, s5_s_q, s5_c_q;
  logic s5_clip_q;
  sat_t e_p, e_q, e_r5, e_r6;
  always_comb begin
    e_p  = q_add(s4_pa_q, s4_xmt4_q);
    e_q  = q_add(s4_qa_q, s4_ymt4_q);
    e_r5 = q_sub(s4_cb6_q, s4_sb5_q);
    e_r6 = q_add(s4_cb5_q, s4_sb6_q);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_p_q    <= e_p.v;
      s5_q_q    <= e_q.v;
      s5_r5_q   <= e_r5.v;
      s5_r6_q   <= e_r6.v;
      s5_r2_q   <= s4_r2_q;
      s5_r3_q   <= s4_r3_q;
      s5_r4_q   <= s4_r4_q;
      s5_r7_q   <= s4_r7_q;
      s5_r8_q   <= s4_r8_q;
      s5_r9_q   <= s4_r9_q;
      s5_r10_q  <= s4_r10_q;
      s5_s_q    <= s4_s_q;
      s5_c_q    <= s4_c_q;
      s5_clip_q <= s4_clip_q | e_p.clip | e_q.clip | e_r5.clip | e_r6.clip;
    end
  end

  // stage 6: rotate p and q
  q_t   s6_sp_q, s6_cq_q, s6_sq_q, s6_cp_q;
  q_t   s6_r2_q, s6_r3_q, s6_r4_q, s6_r5_q, s6_r6_q, s6_r7_q, s6_r8_q, s6_r9_q, s6_r10_q;
  logic s6_clip_q;
  sat_t f_sp, f_cq, f_sq, f_cp;
  always_comb begin
    f_sp = q_mul(s5_s_q, s5_p_q);
    f_cq = q_mul(s5_c_q, s5_q_q);
    f_sq = q_mul(s5_s_q, s5_q_q);
    f_cp = q_mul(s5_c_q, s5_p_q);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_sp_q   <= f_sp.v;
      s6_cq_q   <= f_cq.v;
      s6_sq_q   <= f_sq.v;
      s6_cp_q   <= f_cp.v;
      s6_r2_q   <= s5_r2_q;
      s6_r3_q   <= s5_r3_q;
      s6_r4_q   <= s5_r4_q;
      s6_r5_q   <= s5_r5_q;
      s6_r6_q   <= s5_r6_q;
      s6_r7_q   <= s5_r7_q;
      s6_r8_q   <= s5_r8_q;
      s6_r9_q   <= s5_r9_q;
      s6_r10_q  <= s5_r10_q;
      s6_clip_q <= s5_clip_q | f_sp.clip | f_cq.clip | f_sq.clip | f_cp.clip;
    end
  end

  // stage 7: angle column of the state jacobian, output register
  jac_t jac_q;
  logic sat_q;
  sat_t g_n0, g_r0, g_n1, g_r1;
  always_comb begin
    g_n0 = q_neg(s6_sp_q);
    g_r0 = q_sub(g_n0.v, s6_cq_q);
    g_n1 = q_neg(s6_sq_q);
    g_r1 = q_add(g_n1.v, s6_cp_q);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      jac_q.da_x_theta  <= g_r0.v;
      jac_q.da_y_theta  <= g_r1.v;
      jac_q.da_x_ry     <= s6_r2_q;
      jac_q.da_y_ry     <= s6_r3_q;
      jac_q.da_theta_ry <= s6_r4_q;
      jac_q.db_x_fn     <= s6_r5_q;
      jac_q.db_y_fn     <= s6_r6_q;
      jac_q.db_theta_fn <= s6_r7_q;
      jac_q.db_x_ft     <= s6_r8_q;
      jac_q.db_y_ft     <= s6_r9_q;
      jac_q.db_theta_ft <= s6_r10_q;
      sat_q <= s6_clip_q | g_n0.clip | g_r0.clip | g_n1.clip | g_r1.clip;
    end
  end

  assign valid_o = vld_q[6];
  assign jac_o   = jac_q;
  assign sat_o   = sat_q;

endmodule

FILE: sv/pusher_slider_jacobian_eval_core.sv
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid_i/tready_o       tdata: angle, contact y, fn, ft
// m_axis    out        m_axis_tvalid_o/tready_i       tdata: 11 entries; tuser: saturated
// cfg       in         cfg_we_i (no wait)             cfg_addr_i, cfg_wdata_i
//
// one request per cycle while the pipeline is not held; the path runs through the input
// register, the unrolled rotation stages (one per step), the rounding register
// and seven arithmetic stages
// reset clears valid bits and loads the limit surface with the identity
// the whole pipeline holds when the result register is full and not taken
module pusher_slider_jacobian_eval_core #(
  parameter int CORDIC_STEPS = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [119:0]  s_axis_tdata_i,   // body_angle, contact_y, normal_force, tangent_force
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [351:0]  m_axis_tdata_o,   // da_x_theta .. db_theta_ft, 32 bits each
  output logic [0:0]    m_axis_tuser_o,   // saturated
  input  logic          cfg_we_i,
  input  logic [pslj_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [31:0]   cfg_wdata_i
);
  import pslj_pkg::*;

  cfg_t cfg_q;
  logic en;
  logic cor_vld, out_vld, out_sat;
  q_t   cor_sin, cor_cos;
  ops_t ops_in, cor_ops;
  jac_t jac;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.xx <= 32'sd65536;
      cfg_q.xy <= '0;
      cfg_q.xm <= '0;
      cfg_q.yy <= 32'sd65536;
      cfg_q.ym <= '0;
      cfg_q.mm <= 32'sd65536;
      cfg_q.lx <= '0;
      cfg_q.po <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        REG_LS_XX:    cfg_q.xx <= cfg_wdata_i;
        REG_LS_XY:    cfg_q.xy <= cfg_wdata_i;
        REG_LS_XM:    cfg_q.xm <= cfg_wdata_i;
        REG_LS_YY:    cfg_q.yy <= cfg_wdata_i;
        REG_LS_YM:    cfg_q.ym <= cfg_wdata_i;
        REG_LS_MM:    cfg_q.mm <= cfg_wdata_i;
        REG_LEVER_X:  cfg_q.lx <= cfg_wdata_i;
        REG_PUSH_OFS: cfg_q.po <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline advances unless the result register is held
  assign en              = !out_vld || m_axis_tready_i;
  assign s_axis_tready_o = en;

  assign ops_in.ry = s_axis_tdata_i[50:19];
  assign ops_in.fn = s_axis_tdata_i[82:51];
  assign ops_in.ft = s_axis_tdata_i[114:83];

  pslj_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .angle_i (s_axis_tdata_i[18:0]),
    .ops_i   (ops_in),
    .valid_o (cor_vld),
    .sin_o   (cor_sin),
    .cos_o   (cor_cos),
    .ops_o   (cor_ops)
  );

  pslj_math u_math (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cor_vld),
    .sin_i   (cor_sin),
    .cos_i   (cor_cos),
    .ops_i   (cor_ops),
    .cfg_i   (cfg_q),
    .valid_o (out_vld),
    .jac_o   (jac),
    .sat_o   (out_sat)
  );

  // first field in the lowest bits
  assign m_axis_tvalid_o = out_vld;
  assign m_axis_tdata_o  = {jac.db_theta_ft, jac.db_y_ft, jac.db_x_ft, jac.db_theta_fn,
                            jac.db_y_fn, jac.db_x_fn, jac.da_theta_ry, jac.da_y_ry,
                            jac.da_x_ry, jac.da_y_theta, jac.da_x_theta};
  assign m_axis_tuser_o  = out_sat;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pslj_pkg::*;

  localparam int Steps      = 20;
  localparam int Latency    = Steps + 9;
  localparam int IdleLimit  = 4000;
  localparam int LongStall  = 600;

  typedef struct {
    logic signed [18:0] ang;
    q_t ry;
    q_t fn;
    q_t ft;
  } req_t;

  typedef struct {
    logic [351:0] d;
    logic         sat;
  } jac_exp_t;

  localparam longint AtanTab[30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149,
    1048575, 524287, 262143, 131071, 65535,
    32767, 16383, 8191, 4095, 2047,
    1023, 511, 255, 127, 63, 31, 15, 8, 4, 2};

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid_i = 1'b0;
  logic          s_axis_tready_o;
  logic [119:0]  s_axis_tdata_i = '0;
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i = 1'b0;
  logic [351:0]  m_axis_tdata_o;
  logic [0:0]    m_axis_tuser_o;
  logic          cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [31:0]   cfg_wdata_i = '0;

  req_t     pending_q[$];
  jac_exp_t jac_q[$];
  longint   ls_m[8];
  bit       clip_seen;
  int       err_cnt = 0;
  int       n_req = 0;
  int       n_res = 0;
  int       n_sat = 0;
  int       n_phase = 0;
  int       src_gap = 0;
  int       sink_gap = 0;
  int       idle_cnt = 0;
  bit       sink_block_req = 0;
  bit       sink_block_done = 0;

  string entry_name[11] = '{"da_x_theta", "da_y_theta", "da_x_ry", "da_y_ry",
    "da_theta_ry", "db_x_fn", "db_y_fn", "db_theta_fn", "db_x_ft", "db_y_ft",
    "db_theta_ft"};

  pusher_slider_jacobian_eval_core #(.CORDIC_STEPS(Steps)) dut (.*);

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // saturating q16.16 arithmetic
  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) begin
      clip_seen = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip_seen = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint mul_q(longint a, longint b);
    return clip32((a * b + 64'sd32768) >>> 16);
  endfunction

  function automatic longint add_q(longint a, longint b);
    return clip32(a + b);
  endfunction

  function automatic longint sub_q(longint a, longint b);
    return clip32(a - b);
  endfunction

  // rotation-mode cordic, quadrant folded into +-pi/2
  function automatic void sin_cos(longint ang, output longint s, output longint c);
    longint z, x, y, xs, ys;
    bit     flip;
    z = ang * 16384;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < ((Steps > 30) ? 30 : Steps); i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= AtanTab[i];
      end else begin
        x += ys; y -= xs; z += AtanTab[i];
      end
    end
    x = (x + 8192) >>> 14;
    y = (y + 8192) >>> 14;
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endfunction

  // jacobian entries for one request under the current registers
  function automatic jac_exp_t eval_jacobian(req_t r);
    longint s, c, ry, fn, ft, t2, t4, p, q, b5, b6, b8, b10;
    longint xx, xy, xm, yy, ym, mm, lx, po;
    longint e[11];
    jac_exp_t j;
    xx = ls_m[REG_LS_XX]; xy = ls_m[REG_LS_XY]; xm = ls_m[REG_LS_XM];
    yy = ls_m[REG_LS_YY]; ym = ls_m[REG_LS_YM]; mm = ls_m[REG_LS_MM];
    lx = ls_m[REG_LEVER_X]; po = ls_m[REG_PUSH_OFS];
    ry = r.ry; fn = r.fn; ft = r.ft;
    clip_seen = 0;
    sin_cos(longint'(r.ang), s, c);
    t2 = add_q(po, ry);
    t4 = sub_q(mul_q(lx, ft), mul_q(t2, fn));
    p = add_q(add_q(mul_q(xx, fn), mul_q(xy, ft)), mul_q(xm, t4));
    q = add_q(add_q(mul_q(xy, fn), mul_q(yy, ft)), mul_q(ym, t4));
    e[0] = sub_q(clip32(-mul_q(s, p)), mul_q(c, q));
    e[1] = add_q(clip32(-mul_q(s, q)), mul_q(c, p));
    e[2] = add_q(clip32(-mul_q(mul_q(xm, c), fn)), mul_q(mul_q(ym, s), fn));
    e[3] = sub_q(clip32(-mul_q(mul_q(xm, s), fn)), mul_q(mul_q(ym, c), fn));
    e[4] = clip32(-mul_q(mm, fn));
    b5 = sub_q(xy, mul_q(ym, t2));
    b6 = sub_q(xx, mul_q(xm, t2));
    b8 = add_q(yy, mul_q(ym, lx));
    b10 = add_q(xy, mul_q(xm, lx));
    e[5] = sub_q(mul_q(c, b6), mul_q(s, b5));
    e[6] = add_q(mul_q(c, b5), mul_q(s, b6));
    e[7] = sub_q(xm, mul_q(mm, t2));
    e[8] = sub_q(mul_q(c, b10), mul_q(s, b8));
    e[9] = add_q(mul_q(c, b8), mul_q(s, b10));
    e[10] = add_q(ym, mul_q(mm, lx));
    for (int k = 0; k < 11; k++) j.d[32*k +: 32] = e[k][31:0];
    j.sat = clip_seen;
    return j;
  endfunction

  // operand mix: mostly moderate, some full range and extremes
  function automatic q_t rnd_q();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return q_t'($urandom);
      4: return 32'sd0;
      default: return q_t'($signed($urandom_range(0, 32'h0004_0000)) - 32'sd131072);
    endcase
  endfunction

  function automatic logic signed [18:0] rnd_angle();
    if ($urandom_range(0, 7) == 0) return 19'($urandom);
    return 19'($signed($urandom_range(0, 411774)) - 32'sd205887);
  endfunction

  function automatic int rnd_gap();
    int k;
    k = $urandom_range(0, 19);
    if (k < 12) return 0;
    if (k < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= {5'd0, pending_q[0].ft, pending_q[0].fn, pending_q[0].ry,
                           pending_q[0].ang};
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // result sink with random back-pressure and one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_block_req && !sink_block_done) begin
        sink_block_done <= 1;
        sink_gap <= LongStall;
        m_axis_tready_i <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        sink_gap <= rnd_gap();
      end
    end
  end

  // monitor: predict on request, check on result
  always @(posedge clk_i) begin
    jac_exp_t exp_j;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      jac_q.push_back(eval_jacobian(pending_q[0]));
      void'(pending_q.pop_front());
      n_req <= n_req + 1;
      src_gap <= rnd_gap();
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      n_res <= n_res + 1;
      if (jac_q.size() == 0) begin
        $error("result with no request outstanding");
        err_cnt++;
      end else begin
        exp_j = jac_q.pop_front();
        if (exp_j.sat) n_sat <= n_sat + 1;
        for (int k = 0; k < 11; k++) begin
          if (m_axis_tdata_o[32*k +: 32] !== exp_j.d[32*k +: 32]) begin
            $error("%s: expected %h, got %h", entry_name[k], exp_j.d[32*k +: 32],
                   m_axis_tdata_o[32*k +: 32]);
            err_cnt++;
          end
        end
        if (m_axis_tuser_o[0] !== exp_j.sat) begin
          $error("saturated: expected %b, got %b", exp_j.sat, m_axis_tuser_o[0]);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IdleLimit) begin
      $display("timeout: no handshake for %0d cycles", IdleLimit);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // write all eight registers, one per cycle
  task automatic load_regs(longint v[8]);
    for (int i = 0; i < 8; i++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_addr_i <= CfgAddrW'(i);
      cfg_wdata_i <= v[i][31:0];
      ls_m[i] = longint'($signed(v[i][31:0]));
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_phase++;
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && jac_q.size() == 0);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic add_req(logic signed [18:0] a, q_t ry, q_t fn, q_t ft);
    req_t r;
    r.ang = a; r.ry = ry; r.fn = fn; r.ft = ft;
    pending_q.push_back(r);
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) add_req(rnd_angle(), rnd_q(), rnd_q(), rnd_q());
  endtask

  // stimulus
  initial begin
    longint v[8];
    ls_m = '{65536, 0, 0, 65536, 0, 65536, 0, 0};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: angle extremes, quadrant folds, operand extremes, beyond pi
    add_req(19'sd0, 32'sd0, 32'sd0, 32'sd0);
    add_req(19'sd205887, 32'sd65536, 32'sd65536, 32'sd0);
    add_req(-19'sd205887, 32'sd65536, 32'sd65536, 32'sd65536);
    add_req(19'sd102944, 32'sd0, 32'sd65536, -32'sd65536);
    add_req(-19'sd102944, 32'sd0, 32'sd65536, 32'sd65536);
    add_req(19'sd102943, -32'sd65536, 32'sd131072, 32'sd0);
    add_req(19'sd262143, 32'sd0, 32'sd65536, 32'sd65536);
    add_req(-19'sd262144, 32'sd0, 32'sd65536, 32'sd65536);
    add_req(19'sd51472, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_req(-19'sd51472, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_req(19'sd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'sd0);
    add_req(-19'sd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    drain();

    // extreme registers: all max, then all min
    v = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    load_regs(v);
    add_req(19'sd0, 32'sd0, 32'sd65536, 32'sd65536);
    add_req(19'sd205887, 32'h8000_0000, 32'sd1, 32'sd0);
    add_req(-19'sd102944, 32'sd0, 32'sd0, 32'sd0);
    add_random(30);
    drain();
    v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    load_regs(v);
    add_req(19'sd0, 32'sd0, 32'sd65536, 32'sd65536);
    add_req(-19'sd205887, 32'h7FFF_FFFF, 32'sd1, 32'sd0);
    add_random(30);
    drain();

    // random register sets, the last one the identity; the receiver stalls hard in the first one
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 8; i++) begin
        if (ph % 2 == 0)
          v[i] = longint'($signed($urandom_range(0, 32'h0002_0000))) - 65536;
        else
          v[i] = longint'(rnd_q());
      end
      if (ph == 5) v = '{65536, 0, 0, 65536, 0, 65536, 0, 0};
      load_regs(v);
      if (ph == 0) sink_block_req = 1;
      add_random(150);
      // sender holds until the pipe is empty, then resumes
      wait (pending_q.size() == 0 && jac_q.size() == 0);
      add_random(150);
      drain();
    end

    $display("covered %0d requests, %0d results (%0d saturated) over %0d register sets",
             n_req, n_res, n_sat, n_phase + 1);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/pslj_pkg.sv
sv/pslj_cordic.sv
sv/pslj_math.sv
sv/pusher_slider_jacobian_eval_core.sv
test/testbench.sv
